// ===== hdl/ucps_pkg.sv =====
// ----------------------------------------------------------------------------
// ucps_pkg: shared types and codes for the control pipe sequencer
// Event, action, status and failure reason codes plus the word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package ucps_pkg;

	// Event codes
	localparam logic [3:0] OP_SETUP     = 4'd0;
	localparam logic [3:0] OP_IN_DONE   = 4'd1;
	localparam logic [3:0] OP_IN_FAIL   = 4'd2;
	localparam logic [3:0] OP_OUT_DONE  = 4'd3;
	localparam logic [3:0] OP_OUT_FAIL  = 4'd4;
	localparam logic [3:0] OP_UNCONFIG  = 4'd5;
	localparam logic [3:0] OP_READ      = 4'd6;
	localparam logic [3:0] OP_ACK_OUT   = 4'd7;
	localparam logic [3:0] OP_FAIL_OUT  = 4'd8;
	localparam logic [3:0] OP_WRITE     = 4'd9;
	localparam logic [3:0] OP_FAIL_IN   = 4'd10;

	// Action codes
	localparam logic [3:0] ACT_NONE         = 4'd0;
	localparam logic [3:0] ACT_BEGIN_OUT    = 4'd1;
	localparam logic [3:0] ACT_BEGIN_IN     = 4'd2;
	localparam logic [3:0] ACT_PARTIAL_DONE = 4'd3;
	localparam logic [3:0] ACT_AWAIT_STATUS = 4'd4;
	localparam logic [3:0] ACT_OUT_DONE     = 4'd5;
	localparam logic [3:0] ACT_OUT_DATA     = 4'd6;
	localparam logic [3:0] ACT_IN_ACKED     = 4'd7;
	localparam logic [3:0] ACT_START_READ   = 4'd8;
	localparam logic [3:0] ACT_SEND_STATUS  = 4'd9;
	localparam logic [3:0] ACT_START_WRITE  = 4'd10;
	localparam logic [3:0] ACT_RETRANSMIT   = 4'd11;

	// Pipe status codes
	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_OUT_DATA   = 3'd1;
	localparam logic [2:0] ST_OUT_ACK    = 3'd2;
	localparam logic [2:0] ST_IN_SETUP   = 3'd3;
	localparam logic [2:0] ST_IN_PARTIAL = 3'd4;
	localparam logic [2:0] ST_IN_FINAL   = 3'd5;
	localparam logic [2:0] ST_IN_STATUS  = 3'd6;

	// Failure reasons
	localparam logic [2:0] RSN_PROTOCOL = 3'd1;
	localparam logic [2:0] RSN_SOFTWARE = 3'd2;

	typedef struct packed {
		logic [3:0]  op;
		logic        setup_dir_in;
		logic        setup_handled;
		logic        setup_retransmit;
		logic [2:0]  fail_cause;
		logic [15:0] byte_count;
		logic        write_is_final;
	} ucps_in_t;

	typedef struct packed {
		logic [3:0]  action;
		logic        stall_res;
		logic [3:0]  stall_endpoint;
		logic        fail_notify;
		logic        fail_target_in;
		logic [2:0]  fail_reason;
		logic [15:0] length_out;
		logic [2:0]  status_now;
	} ucps_out_t;

endpackage

`default_nettype wire

// ===== hdl/usb_control_pipe_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// usb_control_pipe_sequencer_unit: USB control endpoint stage sequencer
// Steps a message pipe through SETUP, data and status on bus and firmware
// events and reports one result word per event.
// ----------------------------------------------------------------------------
// Usage:
//   Event words enter on in_valid / in_stall / in_data; one result word per
//   event leaves on out_valid / out_stall / out_data. A word moves at a
//   rising edge with valid high and stall low.
//   Flow: an accepted event is held in the input register, decoded
//   against the pipe status and lands in the result register, which
//   drives out_valid.
//   Throughput: one event per cycle unless out_stall holds a result. The
//   pipe status updates in the same edge that writes the result register,
//   so back-to-back events see the status left by their predecessor.
//   Stall: when out_stall holds a pending result, the input register holds
//   its event and in_stall rises once it is full; nothing is dropped.
//   Reset: arst_n clears both stages, sets the pipe status to idle and the
//   endpoint number to 0.
//   Configuration: cfg_wr_en / cfg_wr_data load the endpoint number that is
//   reported with every stall request; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_control_pipe_sequencer_unit
	import ucps_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,

	input  wire        in_valid,
	output logic       in_stall,
	input  ucps_in_t   in_data,

	output logic       out_valid,
	input  wire        out_stall,
	output ucps_out_t  out_data,

	input  wire        cfg_wr_en,
	input  wire  [3:0] cfg_wr_data
);

	logic       valid_s1;
	ucps_in_t   ev_s1;
	logic       out_valid_q;
	ucps_out_t  out_q;
	logic [2:0] status_q;
	logic [3:0] endpoint_q;

	logic       advance;
	logic       accept;

	// Decode results
	logic [2:0] nxt_status;
	logic [3:0] act;
	logic       stall_req;
	logic       drop;
	logic [2:0] drop_rsn;
	logic       notify;
	logic       tgt_in;
	logic [2:0] rsn;
	logic [15:0] len;
	ucps_out_t  res;

	// The result register frees when empty or being taken this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			endpoint_q <= '0;
		end else if (cfg_wr_en) begin
			endpoint_q <= cfg_wr_data;
		end
	end

	// Input register: load on accept, hold while the result side is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= in_data;
		end
	end

	// Event decode against the current pipe status
	always_comb begin
		nxt_status = status_q;
		act        = ACT_NONE;
		stall_req  = 1'b0;
		drop       = 1'b0;
		drop_rsn   = RSN_SOFTWARE;
		len        = '0;

		case (ev_s1.op)
			OP_SETUP: begin
				if (status_q != ST_IDLE) begin
					if (ev_s1.setup_retransmit) begin
						act = ACT_RETRANSMIT;
					end else begin
						drop      = 1'b1;
						drop_rsn  = RSN_PROTOCOL;
						stall_req = 1'b1;
					end
				end else if (!ev_s1.setup_handled) begin
					stall_req = 1'b1;
				end else if (ev_s1.setup_dir_in) begin
					nxt_status = ST_IN_SETUP;
					act        = ACT_BEGIN_IN;
				end else begin
					nxt_status = ST_OUT_DATA;
					act        = ACT_BEGIN_OUT;
				end
			end
			OP_IN_DONE: begin
				if (status_q == ST_IN_PARTIAL) begin
					act = ACT_PARTIAL_DONE;
				end else if (status_q == ST_IN_FINAL) begin
					nxt_status = ST_IN_STATUS;
					act        = ACT_AWAIT_STATUS;
				end else if (status_q == ST_OUT_ACK) begin
					nxt_status = ST_IDLE;
					act        = ACT_OUT_DONE;
				end else begin
					drop      = 1'b1;
					stall_req = 1'b1;
				end
			end
			OP_IN_FAIL, OP_OUT_FAIL: begin
				drop      = 1'b1;
				drop_rsn  = ev_s1.fail_cause;
				stall_req = 1'b1;
			end
			OP_OUT_DONE: begin
				if (status_q == ST_OUT_DATA) begin
					act = ACT_OUT_DATA;
					len = ev_s1.byte_count;
				end else if (status_q == ST_IN_STATUS) begin
					nxt_status = ST_IDLE;
					act        = ACT_IN_ACKED;
				end else begin
					drop      = 1'b1;
					stall_req = 1'b1;
				end
			end
			OP_UNCONFIG: begin
				// Drop quietly, no stall
				drop     = 1'b1;
				drop_rsn = ev_s1.fail_cause;
			end
			OP_READ: begin
				if (status_q == ST_OUT_DATA) begin
					act = ACT_START_READ;
					len = ev_s1.byte_count;
				end else begin
					drop      = 1'b1;
					stall_req = 1'b1;
				end
			end
			OP_ACK_OUT: begin
				if (status_q == ST_OUT_DATA) begin
					nxt_status = ST_OUT_ACK;
					act        = ACT_SEND_STATUS;
				end else begin
					drop      = 1'b1;
					stall_req = 1'b1;
				end
			end
			OP_FAIL_OUT: begin
				stall_req = 1'b1;
				if (status_q == ST_OUT_DATA) begin
					nxt_status = ST_IDLE;
				end else begin
					drop = 1'b1;
				end
			end
			OP_WRITE: begin
				if (status_q inside {ST_IN_SETUP, ST_IN_PARTIAL}) begin
					nxt_status = ev_s1.write_is_final ? ST_IN_FINAL : ST_IN_PARTIAL;
					act        = ACT_START_WRITE;
					len        = ev_s1.byte_count;
				end else begin
					drop      = 1'b1;
					stall_req = 1'b1;
				end
			end
			OP_FAIL_IN: begin
				stall_req = 1'b1;
				if (status_q inside {ST_IN_SETUP, ST_IN_PARTIAL}) begin
					nxt_status = ST_IDLE;
				end else begin
					drop = 1'b1;
				end
			end
			default: begin
				// Unknown event: ignore
			end
		endcase

		// Notify the active transfer before going idle
		notify = 1'b0;
		tgt_in = 1'b0;
		rsn    = '0;
		if (drop) begin
			if (status_q != ST_IDLE) begin
				notify = 1'b1;
				tgt_in = (status_q >= ST_IN_SETUP);
				rsn    = drop_rsn;
			end
			nxt_status = ST_IDLE;
		end

		res.action         = act;
		res.stall_res      = stall_req;
		res.stall_endpoint = stall_req ? endpoint_q : 4'd0;
		res.fail_notify    = notify;
		res.fail_target_in = tgt_in;
		res.fail_reason    = rsn;
		res.length_out     = len;
		res.status_now     = nxt_status;
	end

	// Result register and pipe status advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_IDLE;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				status_q <= nxt_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
